// File: rtl/core/mpts_pkg.sv
// Shared types, codes and sizes of the multilevel priority task scheduler.
package mpts_pkg;

  // Sizes settled by the widths of the task and priority fields.
  localparam int TASK_W     = 6;
  localparam int LEVEL_W    = 3;
  localparam int NUM_TASKS  = 1 << TASK_W;
  localparam int NUM_LEVELS = 1 << LEVEL_W;

  typedef logic [TASK_W-1:0]  task_t;
  typedef logic [LEVEL_W-1:0] level_t;

  // Operation codes carried by an item.
  localparam logic [2:0] FUNC_NEXT   = 3'd0;
  localparam logic [2:0] FUNC_ADD    = 3'd1;
  localparam logic [2:0] FUNC_SLEEP  = 3'd2;
  localparam logic [2:0] FUNC_WAKEUP = 3'd3;
  localparam logic [2:0] FUNC_REMOVE = 3'd4;

  // Result status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_PENDING = 2'd1;
  localparam logic [1:0] STATUS_DUP     = 2'd2;

  // Update applied to one level cell.
  typedef enum logic [2:0] {
    LV_NOP,
    LV_INIT,
    LV_SET_HEAD,
    LV_SET_TAIL,
    LV_CLEAR
  } lvl_op_t;

  // Command broadcast to the level cells; the level also selects the read.
  typedef struct packed {
    lvl_op_t op;
    level_t  level;
    task_t   value;
  } lvl_cmd_t;

  // Priority search token handed from the more urgent cell to the next.
  typedef struct packed {
    logic   found;
    level_t level;
    task_t  head;
  } srch_t;

  // Contents of the selected level, handed along the chain.
  typedef struct packed {
    logic  nonempty;
    task_t head;
    task_t tail;
  } lvl_rd_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_TAIL,
    ST_ADD_SELF,
    ST_FIND,
    ST_READ,
    ST_UNLINK
  } state_t;

endpackage

// File: rtl/core/mpts_level_cell.sv
// One priority level cell: head, tail and occupancy of one ready queue.
module mpts_level_cell
  import mpts_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  level_t   cell_idx,
  input  lvl_cmd_t cmd,
  input  srch_t    srch_in,
  output srch_t    srch_out,
  input  lvl_rd_t  rd_in,
  output lvl_rd_t  rd_out
);

  logic  nonempty_r;
  task_t head_r;
  task_t tail_r;
  logic  hit;

  assign hit = (cmd.level == cell_idx);

  // Occupancy is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nonempty_r <= 1'b0;
    end else if (hit) begin
      case (cmd.op)
        LV_INIT:  nonempty_r <= 1'b1;
        LV_CLEAR: nonempty_r <= 1'b0;
        default:  nonempty_r <= nonempty_r;
      endcase
    end
  end

  // Head and tail are only looked at while the level is occupied.
  always_ff @(posedge clk) begin
    if (hit) begin
      case (cmd.op)
        LV_INIT: begin
          head_r <= cmd.value;
          tail_r <= cmd.value;
        end
        LV_SET_HEAD: head_r <= cmd.value;
        LV_SET_TAIL: tail_r <= cmd.value;
        default: begin
          head_r <= head_r;
          tail_r <= tail_r;
        end
      endcase
    end
  end

  // The first occupied level along the chain claims the search token.
  always_comb begin
    srch_out = srch_in;
    if (!srch_in.found && nonempty_r) begin
      srch_out = '{found: 1'b1, level: cell_idx, head: head_r};
    end
  end

  // The selected level puts its contents onto the read chain.
  always_comb begin
    rd_out = rd_in;
    if (hit) begin
      rd_out = '{nonempty: nonempty_r, head: head_r, tail: tail_r};
    end
  end

endmodule

// File: rtl/core/multilevel_priority_task_scheduler.sv
// Top level of the multilevel priority task scheduler: sequencer, link memories, level chain.
//
//   channel  | handshake           | fields
//   ---------+---------------------+--------------------------------------------------
//   input    | start / busy        | in_func, in_task_id, in_task_given, in_task_priority,
//            |                     | in_task_is_zombie, in_running_valid, in_running_priority
//   result   | out_strobe (1 cyc)  | out_grant_valid, out_grant_task, out_preempt_request,
//            |                     | out_status
//
// An item is taken when start is high and busy is low; its result strobes when done: refused
// or flag-only items from idle, remove and sleep after read and unlink, add and wakeup after
// add-tail and add-self, next after any add, the search and, if found, read and unlink; the
// states follow one write port per link memory (two next-link writes) and registered read.
// Reset is synchronous and clears the queue and pending flags and every level's occupancy.
// The result is shown for one cycle and cannot be held off; a new item may be accepted in
// the cycle the previous result is shown.
module multilevel_priority_task_scheduler
  import mpts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  logic [5:0]  in_task_id,
  input  logic        in_task_given,
  input  logic [2:0]  in_task_priority,
  input  logic        in_task_is_zombie,
  input  logic        in_running_valid,
  input  logic [2:0]  in_running_priority,
  output logic        out_strobe,
  output logic        out_grant_valid,
  output logic [5:0]  out_grant_task,
  output logic        out_preempt_request,
  output logic [1:0]  out_status
);

  state_t state_r, state_nxt;

  logic [2:0] func_r, func_nxt;
  task_t      t_r, t_nxt;
  level_t     lv_r, lv_nxt;
  logic       rv_r, rv_nxt;
  level_t     rp_r, rp_nxt;
  logic       grant_r, grant_nxt;
  logic       gv_r, gv_nxt;
  task_t      gt_r, gt_nxt;
  logic       pre_r, pre_nxt;
  logic [1:0] st_r, st_nxt;

  logic [NUM_TASKS-1:0] in_queue_r, in_queue_nxt;
  logic [NUM_TASKS-1:0] pending_r, pending_nxt;

  logic       out_strobe_r;
  logic       out_gv_r;
  task_t      out_gt_r;
  logic       out_pre_r;
  logic [1:0] out_st_r;
  logic       finish;

  // Link memories and the record of the level each task is queued on.
  task_t  next_mem [NUM_TASKS];
  task_t  prev_mem [NUM_TASKS];
  level_t qlvl_mem [NUM_TASKS];
  task_t  nx_q, pv_q;
  level_t ql_q;

  logic   nx_we, pv_we, ql_we;
  task_t  nx_waddr, nx_wdata, pv_waddr, pv_wdata;

  lvl_cmd_t lvl_cmd;
  srch_t    srch_c [NUM_LEVELS+1];
  lvl_rd_t  rd_c   [NUM_LEVELS+1];
  srch_t    srch;
  lvl_rd_t  rd;

  logic accept;
  logic in_pend, in_q;
  logic add_ok, add_dup, wk_ok, wk_dup;
  logic do_unlink, at_head, at_tail;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Decode of the incoming item against the task flags.
  assign in_pend = pending_r[in_task_id];
  assign in_q    = in_queue_r[in_task_id];
  assign add_ok  = !in_task_is_zombie && !in_pend && !in_q;
  assign add_dup = !in_task_is_zombie && !in_pend && in_q;
  assign wk_ok   = !in_task_is_zombie && !in_q;
  assign wk_dup  = !in_task_is_zombie && in_q;

  // Level chain: cell 0 is the most urgent level and starts the search.
  assign srch_c[0] = '0;
  assign rd_c[0]   = '0;

  for (genvar i = 0; i < NUM_LEVELS; i++) begin : g_cell
    mpts_level_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (level_t'(i)),
      .cmd      (lvl_cmd),
      .srch_in  (srch_c[i]),
      .srch_out (srch_c[i+1]),
      .rd_in    (rd_c[i]),
      .rd_out   (rd_c[i+1])
    );
  end

  assign srch = srch_c[NUM_LEVELS];
  assign rd   = rd_c[NUM_LEVELS];

  // Unlink decision on the links read in the previous cycle.
  assign do_unlink = grant_r || (in_queue_r[t_r] && (ql_q == lv_r));
  assign at_head   = (rd.head == t_r);
  assign at_tail   = (rd.tail == t_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_func)
            FUNC_NEXT:   state_nxt = (in_task_given && add_ok) ? ST_ADD_TAIL : ST_FIND;
            FUNC_ADD:    state_nxt = add_ok ? ST_ADD_TAIL : ST_IDLE;
            FUNC_SLEEP:  state_nxt = in_pend ? ST_IDLE : ST_READ;
            FUNC_WAKEUP: state_nxt = (in_pend && wk_ok) ? ST_ADD_TAIL : ST_IDLE;
            FUNC_REMOVE: state_nxt = ST_READ;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADD_TAIL: state_nxt = ST_ADD_SELF;
      ST_ADD_SELF: state_nxt = (func_r == FUNC_NEXT) ? ST_FIND : ST_IDLE;
      ST_FIND:     state_nxt = srch.found ? ST_READ : ST_IDLE;
      ST_READ:     state_nxt = ST_UNLINK;
      ST_UNLINK:   state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Datapath controls, flag updates and the result of each state.
  always_comb begin
    func_nxt     = func_r;
    t_nxt        = t_r;
    lv_nxt       = lv_r;
    rv_nxt       = rv_r;
    rp_nxt       = rp_r;
    grant_nxt    = grant_r;
    gv_nxt       = gv_r;
    gt_nxt       = gt_r;
    pre_nxt      = pre_r;
    st_nxt       = st_r;
    in_queue_nxt = in_queue_r;
    pending_nxt  = pending_r;
    finish       = 1'b0;
    nx_we        = 1'b0;
    nx_waddr     = t_r;
    nx_wdata     = t_r;
    pv_we        = 1'b0;
    pv_waddr     = t_r;
    pv_wdata     = t_r;
    ql_we        = 1'b0;
    lvl_cmd      = '{op: LV_NOP, level: lv_r, value: t_r};
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          func_nxt  = in_func;
          t_nxt     = in_task_id;
          lv_nxt    = in_task_priority;
          rv_nxt    = in_running_valid;
          rp_nxt    = in_running_priority;
          grant_nxt = 1'b0;
          gv_nxt    = 1'b0;
          gt_nxt    = '0;
          pre_nxt   = 1'b0;
          st_nxt    = STATUS_OK;
          case (in_func)
            FUNC_NEXT: begin
              if (in_task_given && add_dup) st_nxt = STATUS_DUP;
            end
            FUNC_ADD: begin
              if (add_dup) st_nxt = STATUS_DUP;
              finish = !add_ok;
            end
            FUNC_SLEEP: begin
              if (in_pend) begin
                st_nxt = STATUS_PENDING;
                finish = 1'b1;
              end else begin
                pending_nxt[in_task_id] = 1'b1;
              end
            end
            FUNC_WAKEUP: begin
              if (in_pend) begin
                pending_nxt[in_task_id] = 1'b0;
                if (wk_dup) st_nxt = STATUS_DUP;
                finish = !wk_ok;
              end else begin
                finish = 1'b1;
              end
            end
            FUNC_REMOVE: begin
              finish = 1'b0;
            end
            default: finish = 1'b1;
          endcase
        end
      end
      // Link the task behind the current tail, or open the level with it.
      ST_ADD_TAIL: begin
        pv_we = 1'b1;
        ql_we = 1'b1;
        if (rd.nonempty) begin
          nx_we    = 1'b1;
          nx_waddr = rd.tail;
          nx_wdata = t_r;
          pv_wdata = rd.tail;
          lvl_cmd  = '{op: LV_SET_TAIL, level: lv_r, value: t_r};
        end else begin
          pv_wdata = t_r;
          lvl_cmd  = '{op: LV_INIT, level: lv_r, value: t_r};
        end
        in_queue_nxt[t_r] = 1'b1;
        pre_nxt = rv_r && (rp_r > lv_r);
      end
      // The new tail points to itself.
      ST_ADD_SELF: begin
        nx_we  = 1'b1;
        finish = (func_r != FUNC_NEXT);
      end
      // Take the head of the most urgent occupied level.
      ST_FIND: begin
        if (srch.found) begin
          t_nxt     = srch.head;
          lv_nxt    = srch.level;
          grant_nxt = 1'b1;
          gv_nxt    = 1'b1;
          gt_nxt    = srch.head;
        end else begin
          finish = 1'b1;
        end
      end
      ST_READ: begin
        finish = 1'b0;
      end
      // Splice the task out of its level.
      ST_UNLINK: begin
        finish = 1'b1;
        if (do_unlink) begin
          in_queue_nxt[t_r] = 1'b0;
          if (at_head && at_tail) begin
            lvl_cmd = '{op: LV_CLEAR, level: lv_r, value: t_r};
          end else if (at_head) begin
            lvl_cmd  = '{op: LV_SET_HEAD, level: lv_r, value: nx_q};
            pv_we    = 1'b1;
            pv_waddr = nx_q;
            pv_wdata = nx_q;
          end else if (at_tail) begin
            lvl_cmd  = '{op: LV_SET_TAIL, level: lv_r, value: pv_q};
            nx_we    = 1'b1;
            nx_waddr = pv_q;
            nx_wdata = nx_q;
          end else begin
            nx_we    = 1'b1;
            nx_waddr = pv_q;
            nx_wdata = nx_q;
            pv_we    = 1'b1;
            pv_waddr = nx_q;
            pv_wdata = pv_q;
          end
        end
      end
      default: finish = 1'b0;
    endcase
  end

  // Control registers and task flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      grant_r      <= 1'b0;
      in_queue_r   <= '0;
      pending_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      grant_r      <= grant_nxt;
      in_queue_r   <= in_queue_nxt;
      pending_r    <= pending_nxt;
      out_strobe_r <= finish;
    end
  end

  // Item operands, result accumulators and the result register.
  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    t_r    <= t_nxt;
    lv_r   <= lv_nxt;
    rv_r   <= rv_nxt;
    rp_r   <= rp_nxt;
    gv_r   <= gv_nxt;
    gt_r   <= gt_nxt;
    pre_r  <= pre_nxt;
    st_r   <= st_nxt;
    if (finish) begin
      out_gv_r  <= gv_nxt;
      out_gt_r  <= gt_nxt;
      out_pre_r <= pre_nxt;
      out_st_r  <= st_nxt;
    end
  end

  // Link memories: one write each at its own address, and one registered read at the current task.
  always_ff @(posedge clk) begin
    if (nx_we) next_mem[nx_waddr] <= nx_wdata;
    if (pv_we) prev_mem[pv_waddr] <= pv_wdata;
    if (ql_we) qlvl_mem[t_r] <= lv_r;
    nx_q <= next_mem[t_r];
    pv_q <= prev_mem[t_r];
    ql_q <= qlvl_mem[t_r];
  end

  assign out_strobe          = out_strobe_r;
  assign out_grant_valid     = out_gv_r;
  assign out_grant_task      = out_gt_r;
  assign out_preempt_request = out_pre_r;
  assign out_status          = out_st_r;

`ifndef SYNTHESIS
  // An enqueue only starts for a task that is neither queued nor pending.
  a_add_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADD_TAIL) |-> (!in_queue_r[t_r] && !pending_r[t_r]))
    else $error("enqueue of a queued or pending task");

  // The head found by the search is always a queued task.
  a_head_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIND && srch.found) |-> in_queue_r[srch.head])
    else $error("occupied level head is not queued");

  // A granted task is still queued when it is unlinked.
  a_grant_unlink: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UNLINK && grant_r) |-> in_queue_r[t_r])
    else $error("granted task not queued at unlink");

  // A preempt request comes only with a successful enqueue.
  a_preempt_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_preempt_request) |-> (out_status == STATUS_OK))
    else $error("preempt request with error status");
`endif

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the multilevel priority task scheduler with its own scheduler model.
module tb_top
  import mpts_pkg::*;
();

  // Operation codes the block does not define; they must leave the state untouched.
  localparam logic [2:0] FUNC_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] FUNC_MID_UNUSED   = 3'd6;
  localparam logic [2:0] FUNC_LAST_UNUSED  = 3'd7;
  // Near the end of the stimulus the sender stops idling.
  localparam int         NO_IDLE_TAIL      = 60;
  localparam int         DRAIN_CYCLES      = 20;
  localparam int         RANDOM_ITEMS      = 426;
  // Room for every item of the run and every expected result.
  localparam int         ITEM_CAP          = 512;

  typedef struct packed {
    logic [2:0] func;
    task_t      task_id;
    logic       task_given;
    level_t     task_priority;
    logic       task_is_zombie;
    logic       running_valid;
    level_t     running_priority;
  } sched_req_t;

  typedef struct packed {
    logic       grant_valid;
    task_t      grant_task;
    logic       preempt_request;
    logic [1:0] status;
  } sched_resp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        drv_start = 1'b0;
  sched_req_t  drv_req = '0;
  logic        busy;
  logic        out_strobe;
  logic        out_grant_valid;
  logic [5:0]  out_grant_task;
  logic        out_preempt_request;
  logic [1:0]  out_status;

  // Pending items and expected results, each held in order with its own indexes.
  sched_req_t  req_mem [ITEM_CAP];
  int          req_count = 0;
  int          req_rd = 0;
  sched_resp_t exp_mem [ITEM_CAP];
  int          exp_wr = 0;
  int          exp_rd = 0;
  logic        item_taken = 1'b0;
  int          idle_left = 0;
  int          fail_count = 0;
  sched_resp_t got_resp;
  sched_resp_t want_resp;

  // Scheduler state as the testbench sees it.
  task_t  nxt_link [NUM_TASKS] = '{default: '0};
  task_t  prv_link [NUM_TASKS] = '{default: '0};
  bit     queued   [NUM_TASKS] = '{default: 1'b0};
  bit     asleep   [NUM_TASKS] = '{default: 1'b0};
  level_t home_lvl [NUM_TASKS] = '{default: '0};
  task_t  head_of  [NUM_LEVELS] = '{default: '0};
  task_t  tail_of  [NUM_LEVELS] = '{default: '0};
  bit     occupied [NUM_LEVELS] = '{default: 1'b0};

  multilevel_priority_task_scheduler dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (drv_start),
    .busy                (busy),
    .in_func             (drv_req.func),
    .in_task_id          (drv_req.task_id),
    .in_task_given       (drv_req.task_given),
    .in_task_priority    (drv_req.task_priority),
    .in_task_is_zombie   (drv_req.task_is_zombie),
    .in_running_valid    (drv_req.running_valid),
    .in_running_priority (drv_req.running_priority),
    .out_strobe          (out_strobe),
    .out_grant_valid     (out_grant_valid),
    .out_grant_task      (out_grant_task),
    .out_preempt_request (out_preempt_request),
    .out_status          (out_status)
  );

  // Clock with a period of 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Take a task out of the doubly linked list of its level.
  function automatic void unlink_task(task_t t, level_t lv);
    task_t p;
    task_t n;
    bit    at_head;
    bit    at_tail;
    p       = prv_link[t];
    n       = nxt_link[t];
    at_head = (head_of[lv] == t);
    at_tail = (tail_of[lv] == t);
    if (at_head && at_tail) begin
      occupied[lv] = 1'b0;
    end else if (at_head) begin
      head_of[lv] = n;
    end else if (at_tail) begin
      tail_of[lv] = p;
      nxt_link[p] = n;
    end else begin
      nxt_link[p] = n;
      prv_link[n] = p;
    end
    if (at_head && !at_tail) prv_link[n] = n;
    queued[t] = 1'b0;
  endfunction

  // Append a task to the tail of its level unless it is a zombie, asleep or already queued.
  function automatic logic [1:0] enqueue_task(sched_req_t r, output logic pre);
    task_t  t;
    level_t lv;
    t   = r.task_id;
    lv  = r.task_priority;
    pre = 1'b0;
    if (r.task_is_zombie || asleep[t]) return STATUS_OK;
    if (queued[t]) return STATUS_DUP;
    if (occupied[lv]) begin
      nxt_link[tail_of[lv]] = t;
      prv_link[t]           = tail_of[lv];
    end else begin
      head_of[lv]  = t;
      prv_link[t]  = t;
      occupied[lv] = 1'b1;
    end
    nxt_link[t]  = t;
    tail_of[lv]  = t;
    queued[t]    = 1'b1;
    home_lvl[t]  = lv;
    pre = r.running_valid && (r.running_priority > lv);
    return STATUS_OK;
  endfunction

  // Apply one item to the model state and return the result it should produce.
  function automatic sched_resp_t predict_sched(sched_req_t r);
    sched_resp_t res;
    logic        pre;
    task_t       t;
    level_t      lv;
    res = '0;
    pre = 1'b0;
    t   = r.task_id;
    lv  = r.task_priority;
    case (r.func)
      FUNC_NEXT: begin
        if (r.task_given) res.status = enqueue_task(r, pre);
        for (int i = 0; i < NUM_LEVELS; i++) begin
          if (occupied[i] && !res.grant_valid) begin
            res.grant_valid = 1'b1;
            res.grant_task  = head_of[i];
            unlink_task(head_of[i], level_t'(i));
          end
        end
      end
      FUNC_ADD: begin
        res.status = enqueue_task(r, pre);
      end
      FUNC_SLEEP: begin
        if (asleep[t]) begin
          res.status = STATUS_PENDING;
        end else begin
          asleep[t] = 1'b1;
          if (queued[t] && home_lvl[t] == lv) unlink_task(t, lv);
        end
      end
      FUNC_WAKEUP: begin
        if (asleep[t]) begin
          asleep[t]  = 1'b0;
          res.status = enqueue_task(r, pre);
        end
      end
      FUNC_REMOVE: begin
        if (queued[t] && home_lvl[t] == lv) unlink_task(t, lv);
      end
      default: begin
      end
    endcase
    res.preempt_request = pre;
    return res;
  endfunction

  function automatic sched_req_t mk_req(logic [2:0] func, task_t id, logic given, level_t prio,
                                        logic zombie, logic rv, level_t rp);
    sched_req_t r;
    r.func             = func;
    r.task_id          = id;
    r.task_given       = given;
    r.task_priority    = prio;
    r.task_is_zombie   = zombie;
    r.running_valid    = rv;
    r.running_priority = rp;
    return r;
  endfunction

  // Append one item to the list of pending items.
  function automatic void queue_req(sched_req_t r);
    req_mem[req_count] = r;
    req_count          = req_count + 1;
  endfunction

  // Driver: present the next item at the falling edge, with random idle bursts between items.
  always @(negedge clk) begin
    if (!rst_n) begin
      drv_start <= 1'b0;
    end else if (!drv_start || item_taken) begin
      if (idle_left != 0) begin
        idle_left <= idle_left - 1;
        drv_start <= 1'b0;
      end else if (req_rd < req_count) begin
        drv_req   <= req_mem[req_rd];
        drv_start <= 1'b1;
        req_rd    <= req_rd + 1;
        if (req_count - req_rd - 1 > NO_IDLE_TAIL && $urandom_range(0, 2) == 0)
          idle_left <= $urandom_range(1, 12);
      end else begin
        drv_start <= 1'b0;
      end
    end
  end

  // Monitor: check each strobed result against the oldest expectation, then log new items.
  always @(posedge clk) begin
    if (!rst_n) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= drv_start && !busy;
      if (out_strobe) begin
        got_resp = '{out_grant_valid, out_grant_task, out_preempt_request, out_status};
        if (exp_rd == exp_wr) begin
          $display("%0t: unexpected result gv=%0b task=%0d pre=%0b st=%0d",
                   $time, got_resp.grant_valid, got_resp.grant_task,
                   got_resp.preempt_request, got_resp.status);
          fail_count++;
        end else begin
          want_resp = exp_mem[exp_rd];
          exp_rd    = exp_rd + 1;
          if (got_resp !== want_resp) begin
            $display("%0t: expected %0b %0d %0b %0d, actual %0b %0d %0b %0d",
                     $time, want_resp.grant_valid, want_resp.grant_task,
                     want_resp.preempt_request, want_resp.status,
                     got_resp.grant_valid, got_resp.grant_task,
                     got_resp.preempt_request, got_resp.status);
            fail_count++;
          end
        end
      end
      if (drv_start && !busy) begin
        exp_mem[exp_wr] = predict_sched(drv_req);
        exp_wr          = exp_wr + 1;
      end
    end
  end

  // Reset is held low at the start and released away from the sampling edge.
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Stimulus: directed cases first, then random items, then wait for the block to drain.
  initial begin
    sched_req_t r;
    int         pick;

    // Empty scheduler, adds with and without preemption, duplicate and zombie adds.
    queue_req(mk_req(FUNC_NEXT,   6'd0,  1'b0, 3'd0, 1'b0, 1'b0, 3'd0));
    queue_req(mk_req(FUNC_ADD,    6'd0,  1'b0, 3'd0, 1'b0, 1'b1, 3'd7));
    queue_req(mk_req(FUNC_ADD,    6'd63, 1'b1, 3'd7, 1'b0, 1'b1, 3'd7));
    queue_req(mk_req(FUNC_ADD,    6'd0,  1'b0, 3'd0, 1'b0, 1'b1, 3'd7));
    queue_req(mk_req(FUNC_ADD,    6'd5,  1'b0, 3'd0, 1'b1, 1'b1, 3'd7));
    // Three tasks on one level, then unlink from the middle, the tail and a wrong level.
    queue_req(mk_req(FUNC_ADD,    6'd1,  1'b0, 3'd3, 1'b0, 1'b0, 3'd0));
    queue_req(mk_req(FUNC_ADD,    6'd2,  1'b0, 3'd3, 1'b0, 1'b1, 3'd2));
    queue_req(mk_req(FUNC_ADD,    6'd3,  1'b0, 3'd3, 1'b0, 1'b1, 3'd4));
    queue_req(mk_req(FUNC_REMOVE, 6'd2,  1'b0, 3'd3, 1'b0, 1'b0, 3'd0));
    queue_req(mk_req(FUNC_REMOVE, 6'd3,  1'b0, 3'd3, 1'b0, 1'b0, 3'd0));
    queue_req(mk_req(FUNC_REMOVE, 6'd1,  1'b0, 3'd5, 1'b0, 1'b0, 3'd0));
    // Sleep twice, add while asleep, wake a task that is not asleep, then a real wakeup.
    queue_req(mk_req(FUNC_SLEEP,  6'd1,  1'b0, 3'd3, 1'b0, 1'b0, 3'd0));
    queue_req(mk_req(FUNC_SLEEP,  6'd1,  1'b0, 3'd3, 1'b0, 1'b0, 3'd0));
    queue_req(mk_req(FUNC_ADD,    6'd1,  1'b0, 3'd3, 1'b0, 1'b1, 3'd7));
    queue_req(mk_req(FUNC_WAKEUP, 6'd4,  1'b0, 3'd2, 1'b0, 1'b1, 3'd7));
    queue_req(mk_req(FUNC_WAKEUP, 6'd1,  1'b0, 3'd3, 1'b0, 1'b1, 3'd6));
    // Next with a re-queued previous task, without one, and with a duplicate previous task.
    queue_req(mk_req(FUNC_NEXT,   6'd2,  1'b1, 3'd3, 1'b0, 1'b1, 3'd5));
    queue_req(mk_req(FUNC_NEXT,   6'd0,  1'b0, 3'd0, 1'b0, 1'b0, 3'd0));
    queue_req(mk_req(FUNC_NEXT,   6'd63, 1'b1, 3'd7, 1'b0, 1'b1, 3'd7));
    // Undefined operation codes do nothing.
    queue_req(mk_req(FUNC_FIRST_UNUSED, 6'd63, 1'b1, 3'd7, 1'b1, 1'b1, 3'd7));
    queue_req(mk_req(FUNC_MID_UNUSED,   6'd10, 1'b1, 3'd0, 1'b0, 1'b1, 3'd7));
    queue_req(mk_req(FUNC_LAST_UNUSED,  6'd42, 1'b0, 3'd5, 1'b0, 1'b0, 3'd1));
    // Drain what is left.
    queue_req(mk_req(FUNC_NEXT,   6'd0,  1'b0, 3'd0, 1'b0, 1'b0, 3'd0));
    queue_req(mk_req(FUNC_NEXT,   6'd0,  1'b0, 3'd0, 1'b0, 1'b0, 3'd0));

    // Random items over a small working set of tasks, mostly at their usual level.
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30)      r.func = FUNC_ADD;
      else if (pick < 55) r.func = FUNC_NEXT;
      else if (pick < 70) r.func = FUNC_SLEEP;
      else if (pick < 85) r.func = FUNC_WAKEUP;
      else if (pick < 95) r.func = FUNC_REMOVE;
      else                r.func = 3'($urandom_range(FUNC_FIRST_UNUSED, FUNC_LAST_UNUSED));
      if ($urandom_range(0, 4) != 0) r.task_id = task_t'($urandom_range(0, 15));
      else                           r.task_id = task_t'($urandom_range(0, NUM_TASKS - 1));
      if ($urandom_range(0, 3) != 0) r.task_priority = r.task_id[LEVEL_W-1:0];
      else                           r.task_priority = level_t'($urandom_range(0, 7));
      r.task_given       = ($urandom_range(0, 4) != 0);
      r.task_is_zombie   = ($urandom_range(0, 11) == 0);
      r.running_valid    = 1'($urandom_range(0, 1));
      r.running_priority = level_t'($urandom_range(0, 7));
      queue_req(r);
    end

    // Wait for the last item to be taken and every result to arrive.
    while (req_rd < req_count || drv_start || exp_rd != exp_wr) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog in case the block hangs.
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/mpts_pkg.sv
rtl/core/mpts_level_cell.sv
rtl/core/multilevel_priority_task_scheduler.sv
tb/tb_top.sv
